// ===== hdl/nsf_pkg.sv =====
package nsf_pkg;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_DOLLAR,
    PH_G,
    PH_GP,
    PH_GGA,
    PH_VTG,
    PH_PM,
    PH_PMTK
  } phase_t;

  localparam logic [1:0] KIND_GGA  = 2'd0;
  localparam logic [1:0] KIND_VTG  = 2'd1;
  localparam logic [1:0] KIND_PMTK = 2'd2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_A      = 8'h41;

  typedef struct packed {
    logic        store_valid;
    logic [6:0]  store_index;
    logic [7:0]  store_data;
    logic        done_valid;
    logic [1:0]  done_kind;
    logic [7:0]  done_length;
    logic [15:0] gga_count;
    logic [15:0] vtg_count;
  } result_t;

endpackage

// ===== hdl/nsf_in_if.sv =====
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

// ===== hdl/nsf_out_if.sv =====
interface nsf_out_if;
  logic        valid;
  logic        ready;
  logic        store_valid;
  logic [6:0]  store_index;
  logic [7:0]  store_data;
  logic        done_valid;
  logic [1:0]  done_kind;
  logic [7:0]  done_length;
  logic [15:0] gga_count;
  logic [15:0] vtg_count;

  modport source (
    output valid, output store_valid, output store_index, output store_data,
    output done_valid, output done_kind, output done_length,
    output gga_count, output vtg_count, input ready
  );
  modport sink (
    input valid, input store_valid, input store_index, input store_data,
    input done_valid, input done_kind, input done_length,
    input gga_count, input vtg_count, output ready
  );
endinterface

// ===== hdl/nmea_sentence_filter_unit.sv =====
// Each byte is captured in the input register; its result is then registered in the result register.
// Throughput: one byte per cycle while the result is not stalled; the header parser and counters update together.
// With the result stalled, one further byte is held in the input register.
// Reset (synchronous, rst_n low): parser waits for '$', position, error flag and
// both sentence counters clear, both registers empty.
module nmea_sentence_filter_unit #(
  parameter int MAX_LEN = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  nsf_in_if.sink   in_ch,
  nsf_out_if.source out_ch
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_err_r;
  logic             out_valid_r;
  nsf_pkg::result_t res_r;
  nsf_pkg::result_t res;
  logic             advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  nsf_core #(.MAX_LEN(MAX_LEN)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .rx_byte  (s1_byte_r),
    .rx_error (s1_err_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_err_r  <= in_ch.rx_error;
    end
    if (advance) res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.store_valid = res_r.store_valid;
  assign out_ch.store_index = res_r.store_index;
  assign out_ch.store_data  = res_r.store_data;
  assign out_ch.done_valid  = res_r.done_valid;
  assign out_ch.done_kind   = res_r.done_kind;
  assign out_ch.done_length = res_r.done_length;
  assign out_ch.gga_count   = res_r.gga_count;
  assign out_ch.vtg_count   = res_r.vtg_count;

endmodule

// ===== hdl/nsf_core.sv =====
module nsf_core #(
  parameter int MAX_LEN = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                rx_error,
  output nsf_pkg::result_t    res
);

  localparam int POS_W = $clog2(MAX_LEN);

  nsf_pkg::phase_t  phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             bad_r, bad_nxt;
  logic [15:0]      gga_r, gga_nxt;
  logic [15:0]      vtg_r, vtg_nxt;

  logic [POS_W:0]   n;
  logic             hdr_end;
  logic [7:0]       want;
  logic [31:0]      put_wide;
  logic [31:0]      len_wide;

  assign n        = {1'b0, pos_r} + (POS_W+1)'(1);
  assign hdr_end  = n > (POS_W+1)'(5);
  assign want     = (phase_r == nsf_pkg::PH_GGA)
                    ? ((n == (POS_W+1)'(4)) ? nsf_pkg::CH_G : nsf_pkg::CH_A)
                    : ((n == (POS_W+1)'(4)) ? nsf_pkg::CH_T : nsf_pkg::CH_G);
  assign len_wide = 32'(pos_r) + 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    if (!rx_error) begin
      unique case (phase_r)
        nsf_pkg::PH_WAIT: begin
          if (rx_byte == nsf_pkg::CH_DOLLAR) phase_nxt = nsf_pkg::PH_DOLLAR;
        end
        nsf_pkg::PH_DOLLAR: begin
          priority if (rx_byte == nsf_pkg::CH_DOLLAR) phase_nxt = nsf_pkg::PH_DOLLAR;
          else if (rx_byte == nsf_pkg::CH_G) phase_nxt = nsf_pkg::PH_G;
          else if (rx_byte == nsf_pkg::CH_P) phase_nxt = nsf_pkg::PH_PM;
          else phase_nxt = nsf_pkg::PH_WAIT;
        end
        nsf_pkg::PH_G: begin
          priority if (rx_byte == nsf_pkg::CH_DOLLAR) phase_nxt = nsf_pkg::PH_DOLLAR;
          else if (rx_byte == nsf_pkg::CH_P) phase_nxt = nsf_pkg::PH_GP;
          else phase_nxt = nsf_pkg::PH_WAIT;
        end
        nsf_pkg::PH_GP: begin
          priority if (rx_byte == nsf_pkg::CH_DOLLAR) phase_nxt = nsf_pkg::PH_DOLLAR;
          else if (rx_byte == nsf_pkg::CH_G) phase_nxt = nsf_pkg::PH_GGA;
          else if (rx_byte == nsf_pkg::CH_V) phase_nxt = nsf_pkg::PH_VTG;
          else phase_nxt = nsf_pkg::PH_WAIT;
        end
        nsf_pkg::PH_PM: begin
          priority if (n == (POS_W+1)'(2) && rx_byte == nsf_pkg::CH_M) phase_nxt = phase_r;
          else if (n == (POS_W+1)'(3) && rx_byte == nsf_pkg::CH_T) phase_nxt = phase_r;
          else if (n == (POS_W+1)'(4) && rx_byte == nsf_pkg::CH_K)
            phase_nxt = nsf_pkg::PH_PMTK;
          else phase_nxt = nsf_pkg::PH_WAIT;
        end
        nsf_pkg::PH_GGA, nsf_pkg::PH_VTG: begin
          priority if (hdr_end) begin
            if (rx_byte == nsf_pkg::CH_DOLLAR) phase_nxt = nsf_pkg::PH_DOLLAR;
          end else if (rx_byte != want) begin
            phase_nxt = nsf_pkg::PH_WAIT;
          end else begin
            phase_nxt = phase_r;
          end
        end
        nsf_pkg::PH_PMTK: begin
          if (rx_byte == nsf_pkg::CH_DOLLAR) phase_nxt = nsf_pkg::PH_DOLLAR;
        end
        default: phase_nxt = nsf_pkg::PH_WAIT;
      endcase
    end
  end

  always_comb begin
    logic             start;
    logic             put;
    logic             body;
    logic             commit;
    logic [1:0]       kind;
    logic [POS_W-1:0] put_idx;
    start   = 1'b0;
    put     = 1'b0;
    body    = 1'b0;
    commit  = 1'b0;
    kind    = nsf_pkg::KIND_PMTK;
    put_idx = n[POS_W-1:0];
    if (!rx_error) begin
      unique case (phase_r)
        nsf_pkg::PH_WAIT: start = (rx_byte == nsf_pkg::CH_DOLLAR);
        nsf_pkg::PH_DOLLAR: begin
          start   = (rx_byte == nsf_pkg::CH_DOLLAR);
          put     = (rx_byte == nsf_pkg::CH_G) || (rx_byte == nsf_pkg::CH_P);
          put_idx = POS_W'(1);
        end
        nsf_pkg::PH_G: begin
          start   = (rx_byte == nsf_pkg::CH_DOLLAR);
          put     = (rx_byte == nsf_pkg::CH_P);
          put_idx = POS_W'(2);
        end
        nsf_pkg::PH_GP: begin
          start   = (rx_byte == nsf_pkg::CH_DOLLAR);
          put     = (rx_byte == nsf_pkg::CH_G) || (rx_byte == nsf_pkg::CH_V);
          put_idx = POS_W'(3);
        end
        nsf_pkg::PH_PM: begin
          put = (n == (POS_W+1)'(2) && rx_byte == nsf_pkg::CH_M)
             || (n == (POS_W+1)'(3) && rx_byte == nsf_pkg::CH_T)
             || (n == (POS_W+1)'(4) && rx_byte == nsf_pkg::CH_K);
        end
        nsf_pkg::PH_GGA, nsf_pkg::PH_VTG: begin
          kind = (phase_r == nsf_pkg::PH_GGA) ? nsf_pkg::KIND_GGA : nsf_pkg::KIND_VTG;
          if (hdr_end) body = 1'b1;
          else put = (rx_byte == want);
        end
        nsf_pkg::PH_PMTK: body = 1'b1;
        default: start = 1'b0;
      endcase
      if (body) begin
        if (rx_byte == nsf_pkg::CH_DOLLAR) begin
          start  = 1'b1;
          commit = !bad_r;
        end else begin
          put = n < (POS_W+1)'(MAX_LEN);
        end
      end
    end

    pos_nxt = pos_r;
    bad_nxt = bad_r | rx_error;
    gga_nxt = gga_r;
    vtg_nxt = vtg_r;
    res     = '0;
    if (start) begin
      pos_nxt         = '0;
      bad_nxt         = 1'b0;
      res.store_valid = 1'b1;
      res.store_data  = rx_byte;
    end else if (put) begin
      pos_nxt         = put_idx;
      res.store_valid = 1'b1;
      res.store_data  = rx_byte;
    end
    put_wide        = start ? 32'd0 : 32'(put_idx);
    res.store_index = res.store_valid ? put_wide[6:0] : 7'd0;
    if (commit) begin
      res.done_valid  = 1'b1;
      res.done_kind   = kind;
      res.done_length = len_wide[7:0];
      if (kind == nsf_pkg::KIND_GGA) gga_nxt = gga_r + 16'd1;
      if (kind == nsf_pkg::KIND_VTG) vtg_nxt = vtg_r + 16'd1;
    end
    res.gga_count = gga_nxt;
    res.vtg_count = vtg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nsf_pkg::PH_WAIT;
      pos_r   <= '0;
      bad_r   <= 1'b0;
      gga_r   <= '0;
      vtg_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      bad_r   <= bad_nxt;
      gga_r   <= gga_nxt;
      vtg_r   <= vtg_nxt;
    end
  end

endmodule

// ===== hdl/nsf_checker.sv =====
module nsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        store_valid,
  input logic [6:0]  store_index,
  input logic [7:0]  store_data,
  input logic        done_valid,
  input logic [15:0] gga_count,
  input logic [15:0] vtg_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(store_data) &&
      $stable(gga_count) && $stable(vtg_count))
    else $error("result changed while stalled");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  a_commit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_valid |-> store_valid && store_index == 7'd0 &&
      store_data == nsf_pkg::CH_DOLLAR)
    else $error("commit without new sentence start");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind nmea_sentence_filter_unit nsf_checker u_nsf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .store_valid (out_ch.store_valid),
  .store_index (out_ch.store_index),
  .store_data  (out_ch.store_data),
  .done_valid  (out_ch.done_valid),
  .gga_count   (out_ch.gga_count),
  .vtg_count   (out_ch.vtg_count)
);
